/* rtl/talu_pkg.sv */
// ----------------------------------------------------------------------------
// talu_pkg
// Shared opcodes, item types and constants for the Thumb ALU with flags.
// ----------------------------------------------------------------------------
package talu_pkg;

  // ALU opcodes in instruction encoding order
  typedef enum logic [3:0] {
    OP_AND = 4'd0,
    OP_EOR = 4'd1,
    OP_LSL = 4'd2,
    OP_LSR = 4'd3,
    OP_ASR = 4'd4,
    OP_ADC = 4'd5,
    OP_SBC = 4'd6,
    OP_ROR = 4'd7,
    OP_TST = 4'd8,
    OP_NEG = 4'd9,
    OP_CMP = 4'd10,
    OP_CMN = 4'd11,
    OP_ORR = 4'd12,
    OP_MUL = 4'd13,
    OP_BIC = 4'd14,
    OP_MVN = 4'd15
  } talu_op_e;

  localparam int unsigned DataW = 32;
  localparam int unsigned CycW  = 3;

  // Sign-extension masks that set the multiply cycle count
  localparam logic [DataW-1:0] MulMask1 = 32'hFFFF_FF00;
  localparam logic [DataW-1:0] MulMask2 = 32'hFFFF_0000;
  localparam logic [DataW-1:0] MulMask3 = 32'hFF00_0000;

  // Internal cycle counts
  localparam logic [CycW-1:0] CycNone  = 3'd0;
  localparam logic [CycW-1:0] CycShift = 3'd1;
  localparam logic [CycW-1:0] CycMul1  = 3'd1;
  localparam logic [CycW-1:0] CycMul2  = 3'd2;
  localparam logic [CycW-1:0] CycMul3  = 3'd3;
  localparam logic [CycW-1:0] CycMul4  = 3'd4;

  // Input item
  typedef struct packed {
    talu_op_e         op;
    logic [DataW-1:0] first_operand;
    logic [DataW-1:0] second_operand;
    logic             carry_in;
    logic             overflow_in;
  } talu_req_t;

  // Result item
  typedef struct packed {
    logic [DataW-1:0] alu_result;
    logic             negative_flag;
    logic             zero_flag;
    logic             carry_out;
    logic             overflow_out;
    logic             write_back;
    logic [CycW-1:0]  internal_cycles;
  } talu_rsp_t;

  // Shifter result toward the execute logic
  typedef struct packed {
    logic [DataW-1:0] result;
    logic             carry;
  } talu_shift_t;

endpackage

/* rtl/talu_shifter.sv */
// ----------------------------------------------------------------------------
// talu_shifter
// Register-specified LSL, LSR, ASR and ROR with the shifter carry out.
// ----------------------------------------------------------------------------
module talu_shifter (
  input  talu_pkg::talu_op_e          op_i,
  input  logic [talu_pkg::DataW-1:0]  value_i,
  input  logic [7:0]                  amount_i,
  input  logic                        carry_i,
  output talu_pkg::talu_shift_t       shift_o
);
  import talu_pkg::*;

  logic [4:0]       sh;
  logic             amt_zero;
  logic             amt_lt32;
  logic             amt_eq32;
  logic [DataW:0]   lsl_w;
  logic [DataW:0]   lsr_w;
  logic [DataW:0]   asr_w;
  logic [2*DataW-1:0] ror_w;
  logic [DataW-1:0] ror_r;

  assign sh       = amount_i[4:0];
  assign amt_zero = (amount_i == 8'd0);
  assign amt_lt32 = (amount_i[7:5] == 3'd0);
  assign amt_eq32 = (amount_i == 8'd32);

  // Extend by one bit so the last bit shifted out lands in the carry slot
  assign lsl_w = {1'b0, value_i} << sh;
  assign lsr_w = {value_i, 1'b0} >> sh;
  assign asr_w = $unsigned($signed({value_i, 1'b0}) >>> sh);
  assign ror_w = {value_i, value_i} >> sh;
  assign ror_r = ror_w[DataW-1:0];

  // Select result and carry by opcode and amount range
  always_comb begin
    shift_o.result = value_i;
    shift_o.carry  = carry_i;
    if (!amt_zero) begin
      unique case (op_i)
        OP_LSL: begin
          if (amt_lt32) begin
            shift_o.result = lsl_w[DataW-1:0];
            shift_o.carry  = lsl_w[DataW];
          end else begin
            shift_o.result = '0;
            shift_o.carry  = amt_eq32 ? value_i[0] : 1'b0;
          end
        end
        OP_LSR: begin
          if (amt_lt32) begin
            shift_o.result = lsr_w[DataW:1];
            shift_o.carry  = lsr_w[0];
          end else begin
            shift_o.result = '0;
            shift_o.carry  = amt_eq32 ? value_i[DataW-1] : 1'b0;
          end
        end
        OP_ASR: begin
          if (amt_lt32) begin
            shift_o.result = asr_w[DataW:1];
            shift_o.carry  = asr_w[0];
          end else begin
            shift_o.result = {DataW{value_i[DataW-1]}};
            shift_o.carry  = value_i[DataW-1];
          end
        end
        OP_ROR: begin
          // the rotated top bit is the last bit moved, also for multiples of 32
          shift_o.result = ror_r;
          shift_o.carry  = ror_r[DataW-1];
        end
        default: begin
          shift_o.result = value_i;
          shift_o.carry  = carry_i;
        end
      endcase
    end
  end

endmodule

/* rtl/talu_exec.sv */
// ----------------------------------------------------------------------------
// talu_exec
// Combinational execute stage: logic ops, adder, shifter, multiplier, flags.
// ----------------------------------------------------------------------------
module talu_exec (
  input  talu_pkg::talu_req_t req_i,
  output talu_pkg::talu_rsp_t rsp_o
);
  import talu_pkg::*;

  logic [DataW-1:0] a;
  logic [DataW-1:0] b;
  logic [DataW-1:0] add_x;
  logic [DataW-1:0] add_y;
  logic             add_cin;
  logic [DataW:0]   add_sum;
  logic [DataW-1:0] add_r;
  logic             add_v;
  logic [DataW-1:0] mul_r;
  logic [CycW-1:0]  mul_cyc;
  logic [DataW-1:0] m1;
  logic [DataW-1:0] m2;
  logic [DataW-1:0] m3;
  talu_shift_t      shift;
  logic [DataW-1:0] res;
  logic             c_new;
  logic             v_new;

  assign a = req_i.first_operand;
  assign b = req_i.second_operand;

  // Shared shifter for the register-specified shifts
  talu_shifter u_shifter (
    .op_i     (req_i.op),
    .value_i  (a),
    .amount_i (b[7:0]),
    .carry_i  (req_i.carry_in),
    .shift_o  (shift)
  );

  // Steer adder operands: subtraction adds the inverted operand
  always_comb begin
    add_x   = a;
    add_y   = b;
    add_cin = 1'b0;
    unique case (req_i.op)
      OP_ADC: begin
        add_cin = req_i.carry_in;
      end
      OP_SBC: begin
        add_y   = ~b;
        add_cin = req_i.carry_in;
      end
      OP_CMP: begin
        add_y   = ~b;
        add_cin = 1'b1;
      end
      OP_NEG: begin
        add_x   = '0;
        add_y   = ~b;
        add_cin = 1'b1;
      end
      default: begin
        add_cin = 1'b0;
      end
    endcase
  end

  assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{DataW{1'b0}}, add_cin};
  assign add_r   = add_sum[DataW-1:0];
  assign add_v   = ~(add_x[DataW-1] ^ add_y[DataW-1]) & (add_x[DataW-1] ^ add_r[DataW-1]);

  // Low word of the product
  assign mul_r = a * b;

  // Multiply cycles from the number of leading sign bytes of the first operand
  assign m1 = a & MulMask1;
  assign m2 = a & MulMask2;
  assign m3 = a & MulMask3;

  always_comb begin
    priority if (m1 == MulMask1 || m1 == '0) begin
      mul_cyc = CycMul1;
    end else if (m2 == MulMask2 || m2 == '0) begin
      mul_cyc = CycMul2;
    end else if (m3 == MulMask3 || m3 == '0) begin
      mul_cyc = CycMul3;
    end else begin
      mul_cyc = CycMul4;
    end
  end

  // Select result, flags, write-back and cycle count
  always_comb begin
    res                   = add_r;
    c_new                 = req_i.carry_in;
    v_new                 = req_i.overflow_in;
    rsp_o.write_back      = 1'b1;
    rsp_o.internal_cycles = CycNone;
    unique case (req_i.op)
      OP_AND: res = a & b;
      OP_EOR: res = a ^ b;
      OP_TST: begin
        res              = a & b;
        rsp_o.write_back = 1'b0;
      end
      OP_ORR: res = a | b;
      OP_BIC: res = a & ~b;
      OP_MVN: res = ~b;
      OP_LSL, OP_LSR, OP_ASR, OP_ROR: begin
        res                   = shift.result;
        c_new                 = shift.carry;
        rsp_o.internal_cycles = CycShift;
      end
      OP_ADC, OP_SBC, OP_NEG: begin
        res   = add_r;
        c_new = add_sum[DataW];
        v_new = add_v;
      end
      OP_CMP, OP_CMN: begin
        res              = add_r;
        c_new            = add_sum[DataW];
        v_new            = add_v;
        rsp_o.write_back = 1'b0;
      end
      OP_MUL: begin
        res                   = mul_r;
        rsp_o.internal_cycles = mul_cyc;
      end
      default: res = add_r;
    endcase
  end

  assign rsp_o.alu_result    = res;
  assign rsp_o.negative_flag = res[DataW-1];
  assign rsp_o.zero_flag     = (res == '0);
  assign rsp_o.carry_out     = c_new;
  assign rsp_o.overflow_out  = v_new;

endmodule

/* rtl/thumb_alu_with_flags.sv */
// ----------------------------------------------------------------------------
// thumb_alu_with_flags
// The item passes the input register, then the result register; the strobe rises
// at the edge after the accepting edge.
// Throughput: one item per cycle, busy_o stays low.
// The result is shown for one cycle on rsp_valid_o; the receiver cannot stall.
// Reset clears the valid bits of both registers; no result follows reset.
// ----------------------------------------------------------------------------
module thumb_alu_with_flags (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  talu_pkg::talu_req_t req_i,
  output logic                rsp_valid_o,
  output talu_pkg::talu_rsp_t rsp_o
);
  import talu_pkg::*;

  logic      req_valid_q;
  logic      req_valid_d;
  talu_req_t req_q;
  talu_rsp_t rsp_d;
  talu_rsp_t rsp_q;
  logic      rsp_valid_q;

  // Every cycle can take an item
  assign busy_o      = 1'b0;
  assign req_valid_d = start_i & ~busy_o;

  // Control valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
      rsp_valid_q <= req_valid_q;
    end
  end

  // Capture the item and hold it for the execute stage
  always_ff @(posedge clk_i) begin
    if (req_valid_d) begin
      req_q <= req_i;
    end
  end

  talu_exec u_exec (
    .req_i (req_q),
    .rsp_o (rsp_d)
  );

  // Register the result
  always_ff @(posedge clk_i) begin
    if (req_valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

/* tb/sv/thumb_alu_with_flags_test.sv */
// ----------------------------------------------------------------------------
// thumb_alu_with_flags_test
// Self-checking bench for the Thumb ALU: a directed table of corner cases,
// then random items with random start gaps. Every result is compared field
// by field against a hand-typed result or an in-bench ALU predictor.
// ----------------------------------------------------------------------------
module thumb_alu_with_flags_test;
  timeunit 1ns;
  timeprecision 1ps;

  import talu_pkg::*;

  localparam time         ClkPeriod   = 20ns;
  localparam int unsigned ResetCycles = 9;
  localparam int unsigned RandomItems = 1000;
  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned MaxReports  = 10;

  // One row of the directed table: the item, and a hand-typed result if known
  typedef struct {
    talu_req_t q;
    logic      known;
    talu_rsp_t want;
  } dir_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      start_i     = 1'b0;
  talu_req_t req_i       = '0;
  logic      busy_o;
  logic      rsp_valid_o;
  talu_rsp_t rsp_o;

  // Expected result of the item on req_i, when typed in by hand
  logic      drv_known = 1'b0;
  talu_rsp_t drv_want  = '0;

  talu_rsp_t   alu_rsp_q[$];
  int unsigned mismatch_cnt = 0;
  int unsigned idle_cycles  = 0;
  int unsigned burst_left   = 0;
  dir_row_t    dir_rows[$];

  thumb_alu_with_flags i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Compute the ALU result and flags for one item
  function automatic talu_rsp_t predict_alu(talu_req_t q);
    logic [DataW-1:0] a, b, r;
    logic [DataW:0]   wide;
    logic [7:0]       amt;
    logic [4:0]       rot;
    logic             c, v;
    logic [CycW-1:0]  cyc;
    talu_rsp_t        p;
    a   = q.first_operand;
    b   = q.second_operand;
    c   = q.carry_in;
    v   = q.overflow_in;
    amt = b[7:0];
    r   = '0;
    cyc = CycNone;
    case (q.op)
      OP_AND, OP_TST: r = a & b;
      OP_EOR: r = a ^ b;
      OP_ORR: r = a | b;
      OP_BIC: r = a & ~b;
      OP_MVN: r = ~b;
      OP_LSL: begin
        r   = a;
        cyc = CycShift;
        if (amt > 32) begin
          c = 1'b0;
          r = '0;
        end else if (amt == 32) begin
          c = a[0];
          r = '0;
        end else if (amt != 0) begin
          c = a[32 - amt];
          r = a << amt;
        end
      end
      OP_LSR: begin
        r   = a;
        cyc = CycShift;
        if (amt > 32) begin
          c = 1'b0;
          r = '0;
        end else if (amt == 32) begin
          c = a[31];
          r = '0;
        end else if (amt != 0) begin
          c = a[amt - 1];
          r = a >> amt;
        end
      end
      OP_ASR: begin
        r   = a;
        cyc = CycShift;
        if (amt >= 32) begin
          c = a[31];
          r = {DataW{a[31]}};
        end else if (amt != 0) begin
          c = a[amt - 1];
          r = $signed(a) >>> amt;
        end
      end
      OP_ROR: begin
        r   = a;
        cyc = CycShift;
        rot = amt[4:0];
        if (amt != 0) begin
          if (rot == 0) begin
            c = a[31];
          end else begin
            c = a[rot - 1];
            r = (a >> rot) | (a << (32 - rot));
          end
        end
      end
      OP_ADC, OP_CMN: begin
        wide = {1'b0, a} + {1'b0, b} + ((q.op == OP_ADC) ? {32'd0, c} : 33'd0);
        r    = wide[DataW-1:0];
        c    = wide[DataW];
        v    = (a[31] == b[31]) && (r[31] != a[31]);
      end
      OP_SBC: begin
        // carry is the unsigned no-borrow of a - b - not-carry
        wide = {1'b0, b} + {32'd0, ~q.carry_in};
        r    = a - b - {31'd0, ~q.carry_in};
        c    = ({1'b0, a} >= wide);
        v    = (a[31] != b[31]) && (r[31] != a[31]);
      end
      OP_CMP: begin
        r = a - b;
        c = (a >= b);
        v = (a[31] != b[31]) && (r[31] != a[31]);
      end
      OP_NEG: begin
        r = 32'd0 - b;
        c = (b == 0);
        v = b[31] && r[31];
      end
      OP_MUL: begin
        r = a * b;
        if ((a & MulMask1) == MulMask1 || (a & MulMask1) == 0) cyc = CycMul1;
        else if ((a & MulMask2) == MulMask2 || (a & MulMask2) == 0) cyc = CycMul2;
        else if ((a & MulMask3) == MulMask3 || (a & MulMask3) == 0) cyc = CycMul3;
        else cyc = CycMul4;
      end
      default: r = '0;
    endcase
    p.alu_result      = r;
    p.negative_flag   = r[31];
    p.zero_flag       = (r == 0);
    p.carry_out       = c;
    p.overflow_out    = v;
    p.write_back      = !(q.op == OP_TST || q.op == OP_CMP || q.op == OP_CMN);
    p.internal_cycles = cyc;
    return p;
  endfunction

  function automatic talu_req_t make_req(talu_op_e op, logic [31:0] a, logic [31:0] b,
                                         logic ci, logic vi);
    talu_req_t q;
    q.op             = op;
    q.first_operand  = a;
    q.second_operand = b;
    q.carry_in       = ci;
    q.overflow_in    = vi;
    return q;
  endfunction

  // Table row checked against the predictor
  function automatic dir_row_t pred_row(talu_op_e op, logic [31:0] a, logic [31:0] b,
                                        logic ci, logic vi);
    dir_row_t d;
    d.q     = make_req(op, a, b, ci, vi);
    d.known = 1'b0;
    d.want  = '0;
    return d;
  endfunction

  // Table row with its result typed in; N and Z follow from the result
  function automatic dir_row_t known_row(talu_op_e op, logic [31:0] a, logic [31:0] b,
                                         logic ci, logic vi, logic [31:0] r, logic co,
                                         logic vo, logic wb, logic [CycW-1:0] cyc);
    dir_row_t d;
    d.q                    = make_req(op, a, b, ci, vi);
    d.known                = 1'b1;
    d.want.alu_result      = r;
    d.want.negative_flag   = r[31];
    d.want.zero_flag       = (r == 0);
    d.want.carry_out       = co;
    d.want.overflow_out    = vo;
    d.want.write_back      = wb;
    d.want.internal_cycles = cyc;
    return d;
  endfunction

  // Operand biased toward corner values
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0: return 32'h0000_0000;
          1: return 32'h0000_0001;
          2: return 32'h7FFF_FFFF;
          3: return 32'h8000_0000;
          4: return 32'h8000_0001;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1: return $urandom_range(0, 255);
      2: return 32'hFFFF_FFFF - $urandom_range(0, 255);
      3: return 32'd1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // Shift amount: low byte near the 32 boundary, upper bits sometimes set
  function automatic logic [31:0] rand_amount();
    logic [7:0]  amt;
    logic [23:0] upper;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: amt = 8'($urandom_range(0, 33));
      5, 6: amt = 8'(32 * $urandom_range(1, 7));
      7: amt = 8'($urandom_range(34, 255));
      default: amt = 8'($urandom);
    endcase
    upper = $urandom_range(0, 1) ? 24'($urandom) : 24'd0;
    return {upper, amt};
  endfunction

  // Multiplier operand sign-extended from a random byte count
  function automatic logic [31:0] rand_mul_operand();
    logic [31:0] x;
    x = $urandom;
    case ($urandom_range(1, 4))
      1: return {{24{x[7]}}, x[7:0]};
      2: return {{16{x[15]}}, x[15:0]};
      3: return {{8{x[23]}}, x[23:0]};
      default: return x;
    endcase
  endfunction

  function automatic talu_req_t rand_item();
    talu_op_e    op;
    logic [31:0] a, b;
    op = talu_op_e'(4'($urandom_range(0, 15)));
    a  = (op == OP_MUL && $urandom_range(0, 1)) ? rand_mul_operand() : rand_word();
    if ((op == OP_LSL || op == OP_LSR || op == OP_ASR || op == OP_ROR) &&
        $urandom_range(0, 3) != 0) begin
      b = rand_amount();
    end else if ($urandom_range(0, 15) == 0) begin
      b = a;
    end else begin
      b = rand_word();
    end
    return make_req(op, a, b, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endfunction

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxReports) begin
      $display("%0t mismatch %s: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  // Hold start high with the item until it is taken; idle before it at random
  task automatic send_item(talu_req_t q, logic known, talu_rsp_t want);
    int unsigned gap;
    gap = 0;
    if (burst_left != 0) begin
      burst_left--;
    end else if ($urandom_range(0, 19) == 0) begin
      burst_left = $urandom_range(20, 60);
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:59]:  gap = 0;
        [60:92]: gap = $urandom_range(1, 3);
        default: gap = $urandom_range(10, 40);
      endcase
    end
    if (gap != 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_i     = q;
    drv_known = known;
    drv_want  = want;
    start_i   = 1'b1;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Queue expectations on accepted items, check results, watch for a hang
  always @(posedge clk_i) begin : scoreboard
    talu_rsp_t want;
    if (rst_ni) begin
      if (start_i && busy_o === 1'b0) begin
        alu_rsp_q.push_back(drv_known ? drv_want : predict_alu(req_i));
      end
      if ((start_i && busy_o === 1'b0) || rsp_valid_o === 1'b1) idle_cycles = 0;
      else idle_cycles++;
      if (rsp_valid_o !== 1'b0) begin
        if (alu_rsp_q.size() == 0) begin
          note_mismatch("result with none expected", '0, rsp_o.alu_result);
        end else begin
          want = alu_rsp_q.pop_front();
          if (rsp_o.alu_result !== want.alu_result)
            note_mismatch("alu_result", want.alu_result, rsp_o.alu_result);
          if (rsp_o.negative_flag !== want.negative_flag)
            note_mismatch("negative_flag", want.negative_flag, rsp_o.negative_flag);
          if (rsp_o.zero_flag !== want.zero_flag)
            note_mismatch("zero_flag", want.zero_flag, rsp_o.zero_flag);
          if (rsp_o.carry_out !== want.carry_out)
            note_mismatch("carry_out", want.carry_out, rsp_o.carry_out);
          if (rsp_o.overflow_out !== want.overflow_out)
            note_mismatch("overflow_out", want.overflow_out, rsp_o.overflow_out);
          if (rsp_o.write_back !== want.write_back)
            note_mismatch("write_back", want.write_back, rsp_o.write_back);
          if (rsp_o.internal_cycles !== want.internal_cycles)
            note_mismatch("internal_cycles", want.internal_cycles, rsp_o.internal_cycles);
        end
      end
      if (idle_cycles >= IdleLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin : stimulus
    // Corner cases: shift amounts of 0, 32, above 32 and multiples of 32,
    // carry rules of add and subtract, overflow, every operation at least once
    dir_rows = '{
      known_row(OP_AND, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b1, 32'h0, 1'b1, 1'b1, 1'b1, CycNone),
      pred_row(OP_EOR, 32'hA5A5_A5A5, 32'hFFFF_FFFF, 1'b0, 1'b0),
      known_row(OP_LSL, 32'h1234_5678, 32'h0000_0100, 1'b1, 1'b0,
                32'h1234_5678, 1'b1, 1'b0, 1'b1, CycShift),
      known_row(OP_LSL, 32'h1, 32'd32, 1'b0, 1'b1, 32'h0, 1'b1, 1'b1, 1'b1, CycShift),
      known_row(OP_LSL, 32'hFFFF_FFFF, 32'd33, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0, 1'b1, CycShift),
      known_row(OP_LSR, 32'h8000_0000, 32'd32, 1'b0, 1'b0, 32'h0, 1'b1, 1'b0, 1'b1, CycShift),
      known_row(OP_LSR, 32'hFFFF_FFFF, 32'hFF, 1'b1, 1'b1, 32'h0, 1'b0, 1'b1, 1'b1, CycShift),
      pred_row(OP_LSR, 32'hF000_0001, 32'd1, 1'b0, 1'b0),
      known_row(OP_ASR, 32'h8000_0000, 32'd32, 1'b0, 1'b0,
                32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, CycShift),
      known_row(OP_ASR, 32'h7FFF_FFFF, 32'd200, 1'b1, 1'b1, 32'h0, 1'b0, 1'b1, 1'b1, CycShift),
      known_row(OP_ROR, 32'h8000_0001, 32'd32, 1'b0, 1'b0,
                32'h8000_0001, 1'b1, 1'b0, 1'b1, CycShift),
      known_row(OP_ROR, 32'h7FFF_FFFE, 32'd64, 1'b1, 1'b0,
                32'h7FFF_FFFE, 1'b0, 1'b0, 1'b1, CycShift),
      known_row(OP_ADC, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b1, 32'h0, 1'b1, 1'b0, 1'b1, CycNone),
      known_row(OP_ADC, 32'h7FFF_FFFF, 32'h0, 1'b1, 1'b0,
                32'h8000_0000, 1'b0, 1'b1, 1'b1, CycNone),
      known_row(OP_SBC, 32'h0, 32'h0, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, CycNone),
      known_row(OP_SBC, 32'd5, 32'd5, 1'b1, 1'b1, 32'h0, 1'b1, 1'b0, 1'b1, CycNone),
      pred_row(OP_SBC, 32'h8000_0000, 32'h1, 1'b1, 1'b0),
      pred_row(OP_TST, 32'hF0F0_F0F0, 32'h0F0F_0F0F, 1'b1, 1'b0),
      known_row(OP_NEG, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b1, 32'h0, 1'b1, 1'b0, 1'b1, CycNone),
      known_row(OP_NEG, 32'h0, 32'h8000_0000, 1'b1, 1'b0,
                32'h8000_0000, 1'b0, 1'b1, 1'b1, CycNone),
      known_row(OP_CMP, 32'h1234_5678, 32'h1234_5678, 1'b0, 1'b1,
                32'h0, 1'b1, 1'b0, 1'b0, CycNone),
      known_row(OP_CMN, 32'hFFFF_FFFF, 32'h1, 1'b0, 1'b1, 32'h0, 1'b1, 1'b0, 1'b0, CycNone),
      pred_row(OP_ORR, 32'h8000_0000, 32'h0000_0001, 1'b0, 1'b1),
      pred_row(OP_MUL, 32'hFF12_3456, 32'hFFFF_FFFF, 1'b1, 1'b1),
      pred_row(OP_MUL, 32'h7FFF_FFFF, 32'h1234_5678, 1'b0, 1'b0),
      pred_row(OP_BIC, 32'hFFFF_FFFF, 32'h5555_AAAA, 1'b1, 1'b0),
      known_row(OP_MVN, 32'h0, 32'h0, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, CycNone)
    };

    // Hold reset, then release it away from the rising edge
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send_item(dir_rows[i].q, dir_rows[i].known, dir_rows[i].want);
    repeat (RandomItems) send_item(rand_item(), 1'b0, '0);
    start_i = 1'b0;

    // Drain outstanding results, then allow for a stray late strobe
    while (alu_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* thumb_alu_with_flags.f */
rtl/talu_pkg.sv
rtl/talu_shifter.sv
rtl/talu_exec.sv
rtl/thumb_alu_with_flags.sv
tb/sv/thumb_alu_with_flags_test.sv
